### hdl/wmh_pkg.sv
// wmh_pkg: constants, operation codes and control/status types for word_mix_hash64.
// No dependencies; every other file of the block refers to it by scoped names.

package wmh_pkg;

    localparam int WordW = 64;
    localparam int LenW  = 31;
    localparam int SeedW = 32;
    localparam int HalfW = 32;

    localparam logic [WordW-1:0] MUL_A = 64'hC6A4A7935BD1E995;
    localparam logic [WordW-1:0] MUL_B = 64'h369DEA0F31A53F85;

    localparam int ROT_AMT  = 27;
    localparam int SHIFT_K  = 47;
    localparam int SHIFT_F1 = 33;
    localparam int SHIFT_F2 = 29;
    localparam int SHIFT_F3 = 18;

    // Phases of the shared 32x32 multiplier sequence (one 64-bit product)
    localparam int MulPhases = 5;
    localparam int PhaseW    = $clog2(MulPhases);

    // Datapath operation codes: which product is formed and where it lands
    localparam logic [2:0] OP_SEED = 3'd0;  // len * A, seeds the running hash
    localparam logic [2:0] OP_K1   = 3'd1;  // word * A, then xorshift
    localparam logic [2:0] OP_K2   = 3'd2;  // k * B, xor into hash and rotate
    localparam logic [2:0] OP_HM   = 3'd3;  // h * A + B
    localparam logic [2:0] OP_F1   = 3'd4;  // finalizer h * B
    localparam logic [2:0] OP_F2   = 3'd5;  // finalizer h * A

    typedef struct packed {
        logic       load;     // capture the input beat
        logic       mul_run;  // multiplier sequence active
        logic [2:0] op;       // operation code
        logic       push;     // move finished hash into the output register
    } cmd_t;

    typedef struct packed {
        logic in_msg;    // a message is open
        logic full;      // at least eight bytes left: current word is a full word
        logic mul_done;  // product ready this cycle
        logic out_free;  // output register can take a new hash
    } status_t;

endpackage

### hdl/wmh_ifs.sv
// wmh_ifs: valid/ready channel interfaces of word_mix_hash64.
// Depends on wmh_pkg for field widths.

interface wmh_msg_if;
    logic                       valid;
    logic                       ready;
    logic                       first;
    logic [wmh_pkg::LenW-1:0]   msg_length;
    logic [wmh_pkg::WordW-1:0]  word;

    modport source (output valid, output first, output msg_length, output word, input ready);
    modport sink   (input valid, input first, input msg_length, input word, output ready);
endinterface

interface wmh_hash_if;
    logic                       valid;
    logic                       ready;
    logic [wmh_pkg::WordW-1:0]  hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

interface wmh_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [wmh_pkg::SeedW-1:0]  seed;

    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface

### hdl/wmh_mul.sv
// wmh_mul: 64x64 -> low 64 bit product, built phase by phase on one 32x32 multiplier.
// Depends on wmh_pkg. Operands must hold steady while run is high.

module wmh_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       run,
    input  logic [wmh_pkg::WordW-1:0]  a,
    input  logic [wmh_pkg::WordW-1:0]  b,
    output logic                       done,
    output logic [wmh_pkg::WordW-1:0]  product
);

    localparam int HW = wmh_pkg::HalfW;
    localparam logic [wmh_pkg::PhaseW-1:0] LastPhase = wmh_pkg::PhaseW'(wmh_pkg::MulPhases - 1);

    logic [wmh_pkg::PhaseW-1:0] phase_reg, phase_next;
    logic [wmh_pkg::WordW-1:0]  prod_reg, prod_next;
    logic [wmh_pkg::WordW-1:0]  acc_reg, acc_next;
    logic [HW-1:0]              op_a, op_b;

    // phase 0: lo*lo, phase 1: hi(a)*lo(b), phase 2: lo(a)*hi(b); cross terms keep low half
    always_comb
    begin
        case (phase_reg)
            wmh_pkg::PhaseW'(1):
            begin
                op_a = a[2*HW-1:HW];
                op_b = b[HW-1:0];
            end
            wmh_pkg::PhaseW'(2):
            begin
                op_a = a[HW-1:0];
                op_b = b[2*HW-1:HW];
            end
            default:
            begin
                op_a = a[HW-1:0];
                op_b = b[HW-1:0];
            end
        endcase
    end

    always_comb
    begin
        prod_next  = {{HW{1'b0}}, op_a} * {{HW{1'b0}}, op_b};
        acc_next   = acc_reg;
        phase_next = '0;
        if (run)
        begin
            phase_next = (phase_reg == LastPhase) ? '0 : phase_reg + wmh_pkg::PhaseW'(1);
            case (phase_reg)
                wmh_pkg::PhaseW'(1): acc_next = prod_reg;
                wmh_pkg::PhaseW'(2),
                wmh_pkg::PhaseW'(3): acc_next = acc_reg + {prod_reg[HW-1:0], {HW{1'b0}}};
                default:             acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign done    = run && (phase_reg == LastPhase);
    assign product = acc_reg;

endmodule

### hdl/wmh_dp.sv
// wmh_dp: datapath of word_mix_hash64 - running hash, byte count, seed and output register.
// Depends on wmh_pkg and wmh_mul; driven by commands from wmh_ctrl.

module wmh_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wmh_pkg::cmd_t              cmd,
    output wmh_pkg::status_t           status,
    input  logic [wmh_pkg::LenW-1:0]   in_len,
    input  logic [wmh_pkg::WordW-1:0]  in_word,
    input  logic                       cfg_valid,
    input  logic [wmh_pkg::SeedW-1:0]  cfg_seed,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [wmh_pkg::WordW-1:0]  out_hash
);

    localparam int W = wmh_pkg::WordW;

    logic [wmh_pkg::SeedW-1:0] seed_reg;
    logic [wmh_pkg::LenW-1:0]  len_reg;
    logic [W-1:0]              word_reg;
    logic [W-1:0]              h_reg, h_next;
    logic [W-1:0]              k_reg, k_next;
    logic [wmh_pkg::LenW-1:0]  left_reg, left_next;
    logic                      in_msg_reg, in_msg_next;
    logic                      out_valid_reg;
    logic [W-1:0]              out_hash_reg;

    logic                      full;
    logic [7:0]                byte_en;
    logic [W-1:0]              word_masked;
    logic [W-1:0]              mul_a, mul_b;
    logic                      mul_done;
    logic [W-1:0]              p;
    logic [W-1:0]              mix, hm;
    logic                      cap;

    assign full = |left_reg[wmh_pkg::LenW-1:3];

    // tail keeps only the low (bytes left mod 8) bytes
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            byte_en[i] = full || (3'(i) < left_reg[2:0]);
        end
        for (int i = 0; i < 8; i++)
        begin
            word_masked[8*i +: 8] = word_reg[8*i +: 8] & {8{byte_en[i]}};
        end
    end

    always_comb
    begin
        case (cmd.op)
            wmh_pkg::OP_SEED:
            begin
                mul_a = {{(W - wmh_pkg::LenW){1'b0}}, len_reg};
                mul_b = wmh_pkg::MUL_A;
            end
            wmh_pkg::OP_K1:
            begin
                mul_a = word_masked;
                mul_b = wmh_pkg::MUL_A;
            end
            wmh_pkg::OP_K2:
            begin
                mul_a = k_reg;
                mul_b = wmh_pkg::MUL_B;
            end
            wmh_pkg::OP_F1:
            begin
                mul_a = h_reg;
                mul_b = wmh_pkg::MUL_B;
            end
            default:
            begin
                mul_a = h_reg;
                mul_b = wmh_pkg::MUL_A;
            end
        endcase
    end

    wmh_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .run     (cmd.mul_run),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (p)
    );

    assign cap = cmd.mul_run && mul_done;
    assign mix = h_reg ^ p;
    assign hm  = p + wmh_pkg::MUL_B;

    always_comb
    begin
        h_next      = h_reg;
        k_next      = k_reg;
        left_next   = left_reg;
        in_msg_next = in_msg_reg;
        if (cap)
        begin
            case (cmd.op)
                wmh_pkg::OP_SEED:
                begin
                    h_next      = {{(W - wmh_pkg::SeedW){1'b0}}, seed_reg} ^ p;
                    left_next   = len_reg;
                    in_msg_next = 1'b1;
                end
                wmh_pkg::OP_K1:
                begin
                    k_next = p ^ (p >> wmh_pkg::SHIFT_K);
                end
                wmh_pkg::OP_K2:
                begin
                    h_next = (mix << wmh_pkg::ROT_AMT) | (mix >> (W - wmh_pkg::ROT_AMT));
                end
                wmh_pkg::OP_HM:
                begin
                    if (full)
                    begin
                        h_next    = hm;
                        left_next = left_reg - wmh_pkg::LenW'(8);
                    end
                    else
                    begin
                        // tail absorbed: first finalizer step folded in
                        h_next      = hm ^ (hm >> wmh_pkg::SHIFT_F1);
                        left_next   = '0;
                        in_msg_next = 1'b0;
                    end
                end
                wmh_pkg::OP_F1:
                begin
                    h_next = p ^ (p >> wmh_pkg::SHIFT_F2);
                end
                wmh_pkg::OP_F2:
                begin
                    h_next = p ^ (p >> wmh_pkg::SHIFT_F3);
                end
                default:
                begin
                    h_next = h_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            left_reg      <= '0;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                seed_reg <= cfg_seed;
            end
            left_reg   <= left_next;
            in_msg_reg <= in_msg_next;
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            len_reg  <= in_len;
            word_reg <= in_word;
        end
        if (cmd.push)
        begin
            out_hash_reg <= h_reg;
        end
        h_reg <= h_next;
        k_reg <= k_next;
    end

    assign status.in_msg   = in_msg_reg;
    assign status.full     = full;
    assign status.mul_done = mul_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_hash  = out_hash_reg;

endmodule

### hdl/wmh_ctrl.sv
// wmh_ctrl: sequencing state machine of word_mix_hash64.
// Depends on wmh_pkg; issues cmd_t to wmh_dp and reads its status_t.

module wmh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_first,
    output logic              in_ready,
    input  wmh_pkg::status_t  status,
    output wmh_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SEED = 3'd1;
    localparam logic [2:0] S_K1   = 3'd2;
    localparam logic [2:0] S_K2   = 3'd3;
    localparam logic [2:0] S_HM   = 3'd4;
    localparam logic [2:0] S_F1   = 3'd5;
    localparam logic [2:0] S_F2   = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.mul_run = 1'b0;
        cmd.op      = wmh_pkg::OP_SEED;
        cmd.push    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_first)
                    begin
                        state_next = S_SEED;
                    end
                    else if (status.in_msg)
                    begin
                        state_next = S_K1;
                    end
                end
            end
            S_SEED:
            begin
                cmd.mul_run = 1'b1;
                cmd.op      = wmh_pkg::OP_SEED;
                if (status.mul_done)
                begin
                    state_next = S_K1;
                end
            end
            S_K1:
            begin
                cmd.mul_run = 1'b1;
                cmd.op      = wmh_pkg::OP_K1;
                if (status.mul_done)
                begin
                    state_next = S_K2;
                end
            end
            S_K2:
            begin
                cmd.mul_run = 1'b1;
                cmd.op      = wmh_pkg::OP_K2;
                if (status.mul_done)
                begin
                    state_next = S_HM;
                end
            end
            S_HM:
            begin
                cmd.mul_run = 1'b1;
                cmd.op      = wmh_pkg::OP_HM;
                if (status.mul_done)
                begin
                    state_next = status.full ? S_IDLE : S_F1;
                end
            end
            S_F1:
            begin
                cmd.mul_run = 1'b1;
                cmd.op      = wmh_pkg::OP_F1;
                if (status.mul_done)
                begin
                    state_next = S_F2;
                end
            end
            S_F2:
            begin
                cmd.mul_run = 1'b1;
                cmd.op      = wmh_pkg::OP_F2;
                if (status.mul_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // wait for room in the output register
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/word_mix_hash64.sv
// word_mix_hash64: top level, 64-bit multiply-rotate hash over little-endian message words.
// Depends on wmh_pkg, wmh_ifs, wmh_ctrl, wmh_dp (which holds wmh_mul).
//
//   channel    role   beat contents
//   msg_in     sink   first, msg_length, word
//   hash_out   source hash_value
//   cfg        sink   seed (always ready)
//
// Every 64-bit product runs on the one shared 32x32 multiplier, which sets the rate.
// A full word is accepted, then takes three products (K1, K2, HM); a first word adds a seeding product.
// The tail word adds two finalizer products (F1, F2), then loads the output register.
// msg_in is ready only between words; a finished hash waits in hash_out's register and the
// next message proceeds, stalling only when a second hash is done before the first is taken.
// Reset clears the sequencer, the open-message flag, the byte count, the seed and hash_out valid.

module word_mix_hash64 (
    input  logic        clk,
    input  logic        rst_n,
    wmh_msg_if.sink     msg_in,
    wmh_hash_if.source  hash_out,
    wmh_cfg_if.sink     cfg
);

    wmh_pkg::cmd_t    cmd;
    wmh_pkg::status_t status;
    logic             in_ready;

    assign msg_in.ready = in_ready;
    assign cfg.ready    = 1'b1;

    wmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (msg_in.valid),
        .in_first (msg_in.first),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    wmh_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_len    (msg_in.msg_length),
        .in_word   (msg_in.word),
        .cfg_valid (cfg.valid),
        .cfg_seed  (cfg.seed),
        .out_ready (hash_out.ready),
        .out_valid (hash_out.valid),
        .out_hash  (hash_out.hash_value)
    );

endmodule
